/* rtl/lzhc_pkg.sv */
`default_nettype none
package lzhc_pkg;

    localparam int LZHC_HISTORY_DEPTH = 32512;
    localparam int LZHC_HASH_BITS     = 15;
    localparam int LZHC_MATCH_MAX     = 258;
    localparam int LZHC_BUFFER_BYTES  = 65536;
    localparam int LZHC_MIN_MATCH     = 3;
    localparam int LZHC_CHAIN_W       = 11;
    localparam logic [LZHC_CHAIN_W-1:0] LZHC_CHAIN_RESET = 11'd20;
    localparam int LZHC_POS_W         = 32;
    localparam int LZHC_QUEUE_DEPTH   = 4;

    // one accepted input item as seen by the match engine
    typedef struct packed {
        logic [LZHC_POS_W-1:0] count;
        logic                  ending;
    } lzhc_step_t;

    typedef struct packed {
        logic        is_match;
        logic [7:0]  literal_value;
        logic [14:0] match_distance;
        logic [7:0]  length_minus_three;
        logic        stream_done;
    } lzhc_token_t;

endpackage
`default_nettype wire

/* rtl/lzhc_ram.sv */
`default_nettype none
module lzhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/lzhc_fifo.sv */
`default_nettype none
module lzhc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slots [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slots[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ((wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = do_pop ? ((rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/lzhc_front.sv */
`default_nettype none
module lzhc_front
    import lzhc_pkg::*;
#(
    parameter int BUFFER_BYTES = LZHC_BUFFER_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            take,
    input  wire logic                            operation,
    input  wire logic [7:0]                      data_byte,
    output logic                                 win_we,
    output logic      [$clog2(BUFFER_BYTES)-1:0] win_addr,
    output logic      [7:0]                      win_data,
    output lzhc_step_t                           step
);

    logic [LZHC_POS_W-1:0] br_reg, br_next;
    logic                  end_reg, end_next;
    logic                  store;

    // bytes after end of stream or past a full counter are dropped
    assign store    = take && !operation && !end_reg && (br_reg != '1);
    assign win_we   = store;
    assign win_addr = br_reg[$clog2(BUFFER_BYTES)-1:0];
    assign win_data = data_byte;

    always_comb
    begin
        br_next  = store ? br_reg + 1'b1 : br_reg;
        end_next = end_reg || (take && operation);
    end

    assign step.count  = br_next;
    assign step.ending = end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg  <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            br_reg  <= br_next;
            end_reg <= end_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lzhc_back.sv */
`default_nettype none
module lzhc_back
    import lzhc_pkg::*;
#(
    parameter int HISTORY_DEPTH = LZHC_HISTORY_DEPTH,
    parameter int HASH_BITS     = LZHC_HASH_BITS,
    parameter int MATCH_MAX     = LZHC_MATCH_MAX,
    parameter int BUFFER_BYTES  = LZHC_BUFFER_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [LZHC_CHAIN_W-1:0]         max_chain,
    input  lzhc_step_t                           step,
    input  wire logic                            step_empty,
    output logic                                 step_pop,
    output logic      [$clog2(BUFFER_BYTES)-1:0] win_addr_a,
    output logic      [$clog2(BUFFER_BYTES)-1:0] win_addr_b,
    input  wire logic [7:0]                      win_data_a,
    input  wire logic [7:0]                      win_data_b,
    output lzhc_token_t                          tok,
    input  wire logic                            tok_full,
    output logic                                 tok_push,
    output logic                                 clearing
);

    localparam int WA       = $clog2(BUFFER_BYTES);
    localparam int LINK_AW  = $clog2(HISTORY_DEPTH);
    localparam int HEADS    = 2 ** HASH_BITS;
    localparam int LEN_W    = $clog2(MATCH_MAX + 1);
    localparam int PW       = LZHC_POS_W;
    localparam int SH1      = (HASH_BITS - 7) / 2;
    localparam int SH2      = HASH_BITS - 8;
    localparam int ENT_W    = PW + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_LCHK  = 4'd3;
    localparam logic [3:0] S_H0    = 4'd4;
    localparam logic [3:0] S_H1    = 4'd5;
    localparam logic [3:0] S_H2    = 4'd6;
    localparam logic [3:0] S_H3    = 4'd7;
    localparam logic [3:0] S_CAND  = 4'd8;
    localparam logic [3:0] S_CMP0  = 4'd9;
    localparam logic [3:0] S_CMP1  = 4'd10;
    localparam logic [3:0] S_CEND  = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]           state_reg, state_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;
    logic [PW-1:0]        br_reg, br_next;
    logic                 end_reg, end_next;
    logic [PW-1:0]        cp_reg, cp_next;
    logic [PW-1:0]        ip_reg, ip_next;
    logic [PW-1:0]        hpos_reg, hpos_next;
    logic                 link_mode_reg, link_mode_next;
    logic                 m1_reg, m1_next, m2_reg, m2_next;
    logic [7:0]           b0_reg, b0_next, b1_reg, b1_next;
    logic [HASH_BITS-1:0] h_reg, h_next;
    logic [PW-1:0]        cand_reg, cand_next;
    logic                 have_reg, have_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     best_reg, best_next;
    logic [LEN_W-1:0]     maxlen_reg, maxlen_next;
    logic [PW-1:0]        dist_reg, dist_next;
    logic [PW-1:0]        bdist_reg, bdist_next;
    logic [LZHC_CHAIN_W-1:0] cnt_reg, cnt_next;

    logic                 head_we, link_we;
    logic [HASH_BITS-1:0] head_waddr, head_raddr;
    logic [ENT_W-1:0]     head_wdata, head_rdata, link_rdata;
    logic [LINK_AW-1:0]   link_waddr, link_raddr;
    logic [PW-1:0]        pending, diff, ldiff;
    logic [HASH_BITS-1:0] hash;
    logic [7:0]           b2;
    logic [LZHC_CHAIN_W-1:0] limit;
    logic [LZHC_CHAIN_W:0]   cnt_inc;
    logic [PW-1:0]        cp_adv;

    lzhc_ram #(.WIDTH(ENT_W), .DEPTH(HEADS)) u_heads (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_addr (head_raddr),
        .rd_data (head_rdata)
    );

    // slots repeat with a period of at least the history depth
    lzhc_ram #(.WIDTH(ENT_W), .DEPTH(2 ** LINK_AW)) u_links (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (head_rdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    assign clearing = (state_reg == S_CLEAR);
    assign pending  = br_reg - cp_reg;
    assign diff     = br_reg - hpos_reg;
    assign ldiff    = br_reg - ip_reg;
    assign b2       = m2_reg ? win_data_a : 8'd0;
    assign hash     = HASH_BITS'(b0_reg) ^ (HASH_BITS'(b1_reg) << SH1)
                    ^ (HASH_BITS'(b2) << SH2);
    assign limit    = (max_chain == '0) ? LZHC_CHAIN_W'(1) : max_chain;
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign cp_adv   = (best_reg >= LEN_W'(LZHC_MIN_MATCH)) ? PW'(best_reg) : PW'(1);

    assign head_raddr = hash;
    assign link_raddr = cand_reg[LINK_AW-1:0];
    assign link_waddr = ip_reg[LINK_AW-1:0];

    always_comb
    begin
        tok.is_match           = (best_reg >= LEN_W'(LZHC_MIN_MATCH));
        tok.literal_value      = tok.is_match ? 8'd0 : win_data_a;
        tok.match_distance     = tok.is_match ? bdist_reg[14:0] : 15'd0;
        tok.length_minus_three = tok.is_match ? 8'(best_reg - LEN_W'(LZHC_MIN_MATCH)) : 8'd0;
        tok.stream_done        = end_reg && (cp_reg + cp_adv == br_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        br_next        = br_reg;
        end_next       = end_reg;
        cp_next        = cp_reg;
        ip_next        = ip_reg;
        hpos_next      = hpos_reg;
        link_mode_next = link_mode_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        h_next         = h_reg;
        cand_next      = cand_reg;
        have_next      = have_reg;
        len_next       = len_reg;
        best_next      = best_reg;
        maxlen_next    = maxlen_reg;
        dist_next      = dist_reg;
        bdist_next     = bdist_reg;
        cnt_next       = cnt_reg;
        step_pop       = 1'b0;
        tok_push       = 1'b0;
        head_we        = 1'b0;
        head_waddr     = h_reg;
        head_wdata     = {1'b1, ip_reg};
        link_we        = 1'b0;
        win_addr_a     = cp_reg[WA-1:0];
        win_addr_b     = cp_reg[WA-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!step_empty)
                begin
                    step_pop   = 1'b1;
                    br_next    = step.count;
                    end_next   = step.ending;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (pending == '0 || (pending < PW'(MATCH_MAX) && !end_reg))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    maxlen_next = (pending < PW'(MATCH_MAX)) ? pending[LEN_W-1:0]
                                                            : LEN_W'(MATCH_MAX);
                    state_next  = S_LCHK;
                end
            end
            S_LCHK:
            begin
                // catch up on deferred chain inserts before searching
                if (ip_reg < cp_reg && (end_reg || ldiff > PW'(2)))
                begin
                    hpos_next      = ip_reg;
                    link_mode_next = 1'b1;
                end
                else
                begin
                    hpos_next      = cp_reg;
                    link_mode_next = 1'b0;
                end
                state_next = S_H0;
            end
            S_H0:
            begin
                win_addr_a = hpos_reg[WA-1:0];
                win_addr_b = WA'(hpos_reg + 1'b1);
                m1_next    = diff > PW'(1);
                m2_next    = diff > PW'(2);
                state_next = S_H1;
            end
            S_H1:
            begin
                b0_next    = win_data_a;
                b1_next    = m1_reg ? win_data_b : 8'd0;
                win_addr_a = WA'(hpos_reg + PW'(2));
                state_next = S_H2;
            end
            S_H2:
            begin
                h_next     = hash;
                state_next = S_H3;
            end
            S_H3:
            begin
                if (link_mode_reg)
                begin
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    ip_next    = ip_reg + 1'b1;
                    state_next = S_LCHK;
                end
                else
                begin
                    have_next  = head_rdata[PW];
                    cand_next  = head_rdata[PW-1:0];
                    best_next  = '0;
                    bdist_next = '0;
                    cnt_next   = '0;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                dist_next = cp_reg - cand_reg;
                len_next  = '0;
                if (have_reg && (cp_reg - cand_reg) != '0
                    && (cp_reg - cand_reg) <= PW'(HISTORY_DEPTH))
                begin
                    state_next = S_CMP0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP0:
            begin
                win_addr_a = WA'(cp_reg + PW'(len_reg));
                win_addr_b = WA'(cand_reg + PW'(len_reg));
                state_next = (len_reg < maxlen_reg) ? S_CMP1 : S_CEND;
            end
            S_CMP1:
            begin
                if (win_data_a == win_data_b)
                begin
                    len_next   = len_reg + 1'b1;
                    state_next = S_CMP0;
                end
                else
                begin
                    state_next = S_CEND;
                end
            end
            S_CEND:
            begin
                if (len_reg > best_reg)
                begin
                    best_next  = len_reg;
                    bdist_next = dist_reg;
                end
                cnt_next = cnt_inc[LZHC_CHAIN_W-1:0];
                if ((len_reg > best_reg && len_reg == maxlen_reg)
                    || cnt_inc >= {1'b0, limit})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                have_next  = link_rdata[PW];
                cand_next  = link_rdata[PW-1:0];
                state_next = S_CAND;
            end
            S_DONE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    cp_next    = cp_reg + cp_adv;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cp_reg    <= '0;
            ip_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cp_reg    <= cp_next;
            ip_reg    <= ip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg        <= br_next;
        end_reg       <= end_next;
        hpos_reg      <= hpos_next;
        link_mode_reg <= link_mode_next;
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        b0_reg        <= b0_next;
        b1_reg        <= b1_next;
        h_reg         <= h_next;
        cand_reg      <= cand_next;
        have_reg      <= have_next;
        len_reg       <= len_next;
        best_reg      <= best_next;
        maxlen_reg    <= maxlen_next;
        dist_reg      <= dist_next;
        bdist_reg     <= bdist_next;
        cnt_reg       <= cnt_next;
    end

endmodule
`default_nettype wire

/* rtl/lz77_hash_chain_matcher.sv */
`default_nettype none
// LZ77 hash chain match finder producing deflate pass-1 tokens. Bytes
// (operation 0) and end/drain ticks (operation 1) are pushed in; each push
// yields zero or one token, literal or length/distance, popped from the
// result side in order. A front stage writes bytes into the byte window and
// queues a snapshot of the stream for each transfer; the back engine links
// deferred positions into their hash chains and walks the chain of the
// current position, comparing byte pairs through an address state and a
// compare state in turn. An item that codes nothing passes only the idle and
// evaluate states in the engine. An item that codes a position runs the hash
// states once per deferred link and once for itself, then compares each
// candidate byte by byte, walking at most max_chain candidates (one when
// max_chain is 0); the chain walk through the byte window memory dominates.
// After reset the 2^HASH_BITS head table entries are swept empty while full
// stays high; max_chain writes are taken at any time.
module lz77_hash_chain_matcher
    import lzhc_pkg::*;
#(
    parameter int HISTORY_DEPTH = LZHC_HISTORY_DEPTH,
    parameter int HASH_BITS     = LZHC_HASH_BITS,
    parameter int MATCH_MAX     = LZHC_MATCH_MAX,
    parameter int BUFFER_BYTES  = LZHC_BUFFER_BYTES
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input queue side
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    operation,
    input  wire logic [7:0]              data_byte,
    // result queue side
    output logic                         empty,
    input  wire logic                    pop,
    output logic                         is_match,
    output logic      [7:0]              literal_value,
    output logic      [14:0]             match_distance,
    output logic      [7:0]              length_minus_three,
    output logic                         stream_done,
    // max_chain write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [LZHC_CHAIN_W-1:0] cfg_data
);

    localparam int WA = $clog2(BUFFER_BYTES);

    logic [LZHC_CHAIN_W-1:0] max_chain_reg;
    logic                    take, clearing;
    logic                    q_full, q_empty, q_pop;
    lzhc_step_t              step_in, step_out;
    logic                    win_we;
    logic [WA-1:0]           win_waddr, win_addr_a, win_addr_b;
    logic [7:0]              win_wdata, win_data_a, win_data_b;
    lzhc_token_t             tok_in, tok_out;
    logic                    tok_full, tok_push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chain_reg <= LZHC_CHAIN_RESET;
        end
        else if (cfg_valid)
        begin
            max_chain_reg <= cfg_data;
        end
    end

    // no transfer in while the head table is being cleared
    assign full = q_full || clearing;
    assign take = push && !full;

    lzhc_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .operation (operation),
        .data_byte (data_byte),
        .win_we    (win_we),
        .win_addr  (win_waddr),
        .win_data  (win_wdata),
        .step      (step_in)
    );

    // byte window held twice so the compare reads two positions per cycle
    lzhc_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_win_a (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (win_waddr),
        .wr_data (win_wdata),
        .rd_addr (win_addr_a),
        .rd_data (win_data_a)
    );

    lzhc_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_win_b (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (win_waddr),
        .wr_data (win_wdata),
        .rd_addr (win_addr_b),
        .rd_data (win_data_b)
    );

    // short queue between front and back
    lzhc_fifo #(.WIDTH($bits(lzhc_step_t)), .DEPTH(LZHC_QUEUE_DEPTH)) u_step_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_data (step_in),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (step_out),
        .empty   (q_empty)
    );

    lzhc_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .HASH_BITS     (HASH_BITS),
        .MATCH_MAX     (MATCH_MAX),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_chain  (max_chain_reg),
        .step       (step_out),
        .step_empty (q_empty),
        .step_pop   (q_pop),
        .win_addr_a (win_addr_a),
        .win_addr_b (win_addr_b),
        .win_data_a (win_data_a),
        .win_data_b (win_data_b),
        .tok        (tok_in),
        .tok_full   (tok_full),
        .tok_push   (tok_push),
        .clearing   (clearing)
    );

    // result queue decouples the engine from the consumer
    lzhc_fifo #(.WIDTH($bits(lzhc_token_t)), .DEPTH(2)) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (tok_push),
        .wr_data (tok_in),
        .full    (tok_full),
        .pop     (pop),
        .rd_data (tok_out),
        .empty   (empty)
    );

    assign is_match           = tok_out.is_match;
    assign literal_value      = tok_out.literal_value;
    assign match_distance     = tok_out.match_distance;
    assign length_minus_three = tok_out.length_minus_three;
    assign stream_done        = tok_out.stream_done;

endmodule
`default_nettype wire
